### rtl/core/scalar_kalman_angle_filter_core_assert.svh
// Assertion macros for the scalar Kalman angle filter core.
// Depends on clock and reset signals in the including module.
`ifndef SCALAR_KALMAN_ANGLE_FILTER_CORE_ASSERT_SVH
`define SCALAR_KALMAN_ANGLE_FILTER_CORE_ASSERT_SVH

// Implication in the same cycle.
`define SKAF_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication in the next cycle.
`define SKAF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/skaf_pkg.sv
// Package for the scalar Kalman angle filter core: payload types, widths,
// register codes, constants and saturation helpers. No dependencies.
package skaf_pkg;

   typedef struct packed {
      logic              func;
      logic signed [31:0] gyro_rate;
      logic signed [31:0] accel_tilt;
      logic [15:0]       time_step;
   } req_type;

   typedef struct packed {
      logic signed [31:0] angle_estimate;
      logic [31:0]       uncertainty;
   } rsp_type;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PROCESS_NOISE     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MEASUREMENT_NOISE = 2'd1;

   localparam logic       FUNC_UPDATE  = 1'b0;
   localparam logic       FUNC_RESTART = 1'b1;

   localparam logic [31:0] PROCESS_NOISE_RESET     = 32'd26844;
   localparam logic [31:0] MEASUREMENT_NOISE_RESET = 32'd10737418;
   localparam logic [31:0] Q30_ONE                 = 32'h4000_0000;

   localparam int MUL_A_WIDTH = 33;
   localparam int MUL_B_WIDTH = 31;
   localparam int MUL_P_WIDTH = MUL_A_WIDTH + MUL_B_WIDTH;
   localparam int DIV_Q_WIDTH = 31;
   localparam int COUNT_WIDTH = 5;

   localparam logic [COUNT_WIDTH-1:0] MUL_LAST = COUNT_WIDTH'(MUL_B_WIDTH - 1);
   localparam logic [COUNT_WIDTH-1:0] DIV_LAST = COUNT_WIDTH'(DIV_Q_WIDTH - 1);
   localparam logic [DIV_Q_WIDTH-1:0] GAIN_ONE = DIV_Q_WIDTH'(32'h4000_0000);

   typedef logic [MUL_A_WIDTH-1:0] mul_a_type;
   typedef logic [MUL_B_WIDTH-1:0] mul_b_type;
   typedef logic [MUL_P_WIDTH-1:0] mul_p_type;
   typedef logic [DIV_Q_WIDTH-1:0] gain_type;

   function automatic logic [31:0] sat_s32(input logic [34:0] v);
      logic [31:0] r;
      if (!v[34] && (v[33:31] != 3'b000)) begin
         r = 32'h7FFF_FFFF;
      end else if (v[34] && (v[33:31] != 3'b111)) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] sat_u32(input logic [33:0] v);
      logic [31:0] r;
      if (v[33:32] != 2'b00) begin
         r = 32'hFFFF_FFFF;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### rtl/core/skaf_serial_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
// Depends on skaf_pkg for operand and product types.
module skaf_serial_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  skaf_pkg::mul_a_type a,
   input  skaf_pkg::mul_b_type b,
   output logic               done,
   output skaf_pkg::mul_p_type product
);
   import skaf_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   mul_a_type              a_ff, a_in;
   logic [MUL_A_WIDTH-1:0] hi_ff, hi_in;
   mul_b_type              lo_ff, lo_in;
   mul_a_type              addend;
   logic [MUL_A_WIDTH:0]   sum;

   always_comb begin
      addend  = lo_ff[0] ? a_ff : '0;
      sum     = {1'b0, hi_ff} + {1'b0, addend};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = a;
         hi_in   = '0;
         lo_in   = b;
      end else if (busy_ff) begin
         hi_in  = sum[MUL_A_WIDTH:1];
         lo_in  = {sum[0], lo_ff[MUL_B_WIDTH-1:1]};
         cnt_in = cnt_ff + COUNT_WIDTH'(1);
         if (cnt_ff == MUL_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

### rtl/core/skaf_serial_div.sv
// Restoring divider for the filter gain, one quotient bit per cycle.
// Forms (p*2^30 + s/2) / s; depends on skaf_pkg for widths.
module skaf_serial_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [31:0]       p,
   input  logic [32:0]       s,
   output logic              done,
   output skaf_pkg::gain_type quotient
);
   import skaf_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [32:0]            rem_ff, rem_in;
   logic [32:0]            s_ff, s_in;
   gain_type               qd_ff, qd_in;
   logic [32:0]            upper;
   logic [33:0]            rem_shift;
   logic [34:0]            diff;
   logic                   qbit;

   always_comb begin
      upper     = {1'b0, p} + {31'b0, s[32:31]};
      rem_shift = {rem_ff, qd_ff[DIV_Q_WIDTH-1]};
      diff      = {1'b0, rem_shift} - {2'b00, s_ff};
      qbit      = !diff[34];
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      s_in      = s_ff;
      qd_in     = qd_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {1'b0, upper[32:1]};
         s_in    = s;
         qd_in   = {upper[0], s[30:1]};
      end else if (busy_ff) begin
         rem_in = qbit ? diff[32:0] : rem_shift[32:0];
         qd_in  = {qd_ff[DIV_Q_WIDTH-2:0], qbit};
         cnt_in = cnt_ff + COUNT_WIDTH'(1);
         if (cnt_ff == DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      s_ff   <= s_in;
      qd_ff  <= qd_in;
   end

   assign done     = done_ff;
   assign quotient = qd_ff;

endmodule

### rtl/core/scalar_kalman_angle_filter_core.sv
// Top level of the scalar Kalman angle filter: sequencer, state and channels.
// Depends on skaf_pkg, skaf_serial_mul, skaf_serial_div and the assert header.
//
// Usage:
//   req channel: one transaction carries func, gyro_rate, accel_tilt and
//   time_step. func restart clears the angle to 0 and the variance to 1.0.
//   rsp channel: every request transaction yields exactly one response with
//   the angle and variance held after it.
//   csr channel: index 0 writes process_noise, index 1 measurement_noise;
//   other indexes are dropped. Always ready; write only while idle.
// Sequence: an update runs from acceptance to rsp_valid through four
//   passes of the shared bit-serial multiplier and one pass of the gain
//   divider, each launched from a start state and awaited in a wait
//   state, plus the ST_SUMS and ST_FIN states. A restart goes from idle
//   straight to ST_FIN. One transaction is in work at a time; the next
//   request is accepted in the cycle after the response is loaded.
// Reset: synchronous, active high; clears the filter state to angle 0 and
//   variance 1.0 and loads the noise registers with their defaults.
// Stall: a finished response is held in the output register while rsp_ready
//   is low; the next request is still accepted and computed, and its result
//   waits until the held response is taken.
`include "scalar_kalman_angle_filter_core_assert.svh"

module scalar_kalman_angle_filter_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  skaf_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output skaf_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [skaf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [31:0]                           csr_wdata
);
   import skaf_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_M1S  = 4'd1;
   localparam logic [3:0] ST_M1W  = 4'd2;
   localparam logic [3:0] ST_M2S  = 4'd3;
   localparam logic [3:0] ST_M2W  = 4'd4;
   localparam logic [3:0] ST_SUMS = 4'd5;
   localparam logic [3:0] ST_DIVS = 4'd6;
   localparam logic [3:0] ST_DIVW = 4'd7;
   localparam logic [3:0] ST_M3S  = 4'd8;
   localparam logic [3:0] ST_M3W  = 4'd9;
   localparam logic [3:0] ST_M4S  = 4'd10;
   localparam logic [3:0] ST_M4W  = 4'd11;
   localparam logic [3:0] ST_FIN  = 4'd12;

   logic [3:0]  state_ff, state_in;
   logic [31:0] process_noise_ff, process_noise_in;
   logic [31:0] measurement_noise_ff, measurement_noise_in;
   logic [31:0] angle_ff, angle_in;
   logic [31:0] var_ff, var_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] meas_ff, meas_in;
   logic [15:0] dt_ff, dt_in;
   logic [31:0] pred_ff, pred_in;
   logic [31:0] p_ff, p_in;
   logic [32:0] s_ff, s_in;
   logic        innov_neg_ff, innov_neg_in;
   logic [32:0] innov_mag_ff, innov_mag_in;
   gain_type    gain_ff, gain_in;

   logic        mul_start;
   mul_a_type   mul_a;
   mul_b_type   mul_b;
   logic        mul_done;
   mul_p_type   mul_product;
   logic        div_start;
   logic        div_done;
   gain_type    div_quotient;

   logic [31:0] rate_mag;
   logic [32:0] r1;
   logic [32:0] r2;
   logic [33:0] r3;
   logic [34:0] angle_ext;
   logic [34:0] pred_ext;
   logic [34:0] pred_sum;
   logic [34:0] corr_sum;
   logic [33:0] var_sum;
   logic [32:0] innov;
   logic        out_free;

   skaf_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   skaf_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .p        (p_ff),
      .s        (s_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      rate_mag = rate_ff[31] ? (~rate_ff + 32'd1) : rate_ff;
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         ST_M1S: begin
            mul_start = 1'b1;
            mul_a     = {1'b0, rate_mag};
            mul_b     = {15'b0, dt_ff};
         end
         ST_M2S: begin
            mul_start = 1'b1;
            mul_a     = {1'b0, process_noise_ff};
            mul_b     = {15'b0, dt_ff};
         end
         ST_M3S: begin
            mul_start = 1'b1;
            mul_a     = innov_mag_ff;
            mul_b     = gain_ff;
         end
         ST_M4S: begin
            mul_start = 1'b1;
            mul_a     = {1'b0, p_ff};
            mul_b     = GAIN_ONE - gain_ff;
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   assign div_start = (state_ff == ST_DIVS);

   always_comb begin
      r1        = {1'b0, mul_product[47:16]} + {32'b0, mul_product[15]};
      r2        = r1;
      r3        = mul_product[63:30] + {33'b0, mul_product[29]};
      angle_ext = {{3{angle_ff[31]}}, angle_ff};
      pred_ext  = {{3{pred_ff[31]}}, pred_ff};
      pred_sum  = rate_ff[31] ? (angle_ext - {2'b00, r1}) : (angle_ext + {2'b00, r1});
      corr_sum  = innov_neg_ff ? (pred_ext - {1'b0, r3}) : (pred_ext + {1'b0, r3});
      var_sum   = {2'b00, var_ff} + {1'b0, r2};
      innov     = {meas_ff[31], meas_ff} - {pred_ff[31], pred_ff};
      out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in             = state_ff;
      process_noise_in     = process_noise_ff;
      measurement_noise_in = measurement_noise_ff;
      angle_in             = angle_ff;
      var_in               = var_ff;
      rsp_valid_in         = rsp_valid_ff && !rsp_ready;
      rsp_data_in          = rsp_data_ff;
      rate_in              = rate_ff;
      meas_in              = meas_ff;
      dt_in                = dt_ff;
      pred_in              = pred_ff;
      p_in                 = p_ff;
      s_in                 = s_ff;
      innov_neg_in         = innov_neg_ff;
      innov_mag_in         = innov_mag_ff;
      gain_in              = gain_ff;

      if (csr_valid) begin
         unique case (csr_index)
            REG_PROCESS_NOISE:     process_noise_in     = csr_wdata;
            REG_MEASUREMENT_NOISE: measurement_noise_in = csr_wdata;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rate_in = req_data.gyro_rate;
               meas_in = req_data.accel_tilt;
               dt_in   = req_data.time_step;
               if (req_data.func == FUNC_RESTART) begin
                  angle_in = '0;
                  var_in   = Q30_ONE;
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_M1S;
               end
            end
         end
         ST_M1S:  state_in = ST_M1W;
         ST_M1W: begin
            if (mul_done) begin
               pred_in  = sat_s32(pred_sum);
               state_in = ST_M2S;
            end
         end
         ST_M2S:  state_in = ST_M2W;
         ST_M2W: begin
            if (mul_done) begin
               p_in     = sat_u32(var_sum);
               state_in = ST_SUMS;
            end
         end
         ST_SUMS: begin
            s_in         = {1'b0, p_ff} + {1'b0, measurement_noise_ff};
            innov_neg_in = innov[32];
            innov_mag_in = innov[32] ? (~innov + 33'd1) : innov;
            state_in     = ST_DIVS;
         end
         ST_DIVS: state_in = ST_DIVW;
         ST_DIVW: begin
            if (div_done) begin
               if (s_ff == '0) begin
                  gain_in = '0;
               end else if (div_quotient > GAIN_ONE) begin
                  gain_in = GAIN_ONE;
               end else begin
                  gain_in = div_quotient;
               end
               state_in = ST_M3S;
            end
         end
         ST_M3S:  state_in = ST_M3W;
         ST_M3W: begin
            if (mul_done) begin
               angle_in = sat_s32(corr_sum);
               state_in = ST_M4S;
            end
         end
         ST_M4S:  state_in = ST_M4W;
         ST_M4W: begin
            if (mul_done) begin
               var_in   = sat_u32(r3);
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.angle_estimate = angle_ff;
               rsp_data_in.uncertainty    = var_ff;
               state_in                   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= ST_IDLE;
         process_noise_ff     <= PROCESS_NOISE_RESET;
         measurement_noise_ff <= MEASUREMENT_NOISE_RESET;
         angle_ff             <= '0;
         var_ff               <= Q30_ONE;
         rsp_valid_ff         <= 1'b0;
      end else begin
         state_ff             <= state_in;
         process_noise_ff     <= process_noise_in;
         measurement_noise_ff <= measurement_noise_in;
         angle_ff             <= angle_in;
         var_ff               <= var_in;
         rsp_valid_ff         <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      rate_ff      <= rate_in;
      meas_ff      <= meas_in;
      dt_ff        <= dt_in;
      pred_ff      <= pred_in;
      p_ff         <= p_in;
      s_ff         <= s_in;
      innov_neg_ff <= innov_neg_in;
      innov_mag_ff <= innov_mag_in;
      gain_ff      <= gain_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   `SKAF_ASSERT_NEXT(a_accept_leaves_idle, req_valid && req_ready, state_ff != ST_IDLE, "accepted transaction left sequencer idle")
   `SKAF_ASSERT_IMPLIES(a_mul_done_in_wait, mul_done, state_ff == ST_M1W || state_ff == ST_M2W || state_ff == ST_M3W || state_ff == ST_M4W, "multiplier finished outside a wait state")
   `SKAF_ASSERT_IMPLIES(a_div_done_in_wait, div_done, state_ff == ST_DIVW, "divider finished outside its wait state")
   `SKAF_ASSERT_IMPLIES(a_gain_bounded, state_ff == ST_M3S, gain_ff <= GAIN_ONE, "gain above one at correction")

endmodule
